### hw/rtl/gtem_pkg.sv
// Shared types, sizes and register indexes for the gradient threshold edge map.
// No dependencies.
package gtem_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int SIZE_W     = 12;
    localparam int PIX_W      = 8;
    localparam int CFG_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);

    localparam logic [SIZE_W-1:0] MAX_W_SIZE = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] MAX_H_SIZE = SIZE_W'(MAX_HEIGHT);
    localparam logic [SIZE_W-1:0] MIN_SIZE   = SIZE_W'(1);

    localparam logic [PIX_W-1:0] EDGE_ON  = 8'd255;
    localparam logic [PIX_W-1:0] EDGE_OFF = 8'd0;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd2;

    localparam logic [SIZE_W-1:0] RST_WIDTH  = 12'd640;
    localparam logic [SIZE_W-1:0] RST_HEIGHT = 12'd480;

    typedef struct packed {
        logic             edge_hit;
        logic             has_edge;
        logic             has_zero;
        logic             last_col;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } item_t;

    function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
        abs_diff = (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

### hw/rtl/gradient_threshold_edge_map.sv
// Gradient threshold edge map, top level: config registers, front end, queue, back end.
// Words pass the front end staging register, the queue and the output register in turn.
// Throughput: one pixel per cycle while the queue has room; one line buffer write and read
// per pixel; a last-row pixel gives two words (one at height 1), sent one per ready cycle.
// Reset: async active low; restores config defaults, clears counters, queue and output
// valid; line buffer is not cleared. Depends on gtem_pkg, gtem_front, gtem_fifo, gtem_back.
module gradient_threshold_edge_map
    import gtem_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [PIX_W-1:0]     pixel,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [PIX_W-1:0]     edge_value,
    output logic [ROW_W-1:0]     out_row,
    output logic [COL_W-1:0]     out_col,
    output logic                 frame_end
);

    logic [PIX_W-1:0]  threshold_reg;
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    logic [SIZE_W-1:0] width_lim;
    logic [SIZE_W-1:0] height_lim;

    logic  q_push;
    logic  q_pop;
    logic  q_full;
    logic  q_empty;
    item_t q_item;
    item_t q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
            width_reg     <= RST_WIDTH;
            height_reg    <= RST_HEIGHT;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_THRESHOLD: threshold_reg <= cfg_wdata[PIX_W-1:0];
                REG_WIDTH:     width_reg     <= cfg_wdata[SIZE_W-1:0];
                REG_HEIGHT:    height_reg    <= cfg_wdata[SIZE_W-1:0];
                default:       ;
            endcase
        end
    end

    assign width_lim  = (width_reg == '0) ? MIN_SIZE :
                        ((width_reg > MAX_W_SIZE) ? MAX_W_SIZE : width_reg);
    assign height_lim = (height_reg == '0) ? MIN_SIZE :
                        ((height_reg > MAX_H_SIZE) ? MAX_H_SIZE : height_reg);

    gtem_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pixel      (pixel),
        .threshold  (threshold_reg),
        .width_lim  (width_lim),
        .height_lim (height_lim),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (q_item)
    );

    gtem_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    gtem_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .edge_value (edge_value),
        .out_row    (out_row),
        .out_col    (out_col),
        .frame_end  (frame_end)
    );

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    a_end_on_last_col: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_end) |->
            (edge_value == EDGE_OFF && ({1'b0, out_col} + SIZE_W'(1)) >= width_lim))
        else $error("frame end word not a zero word on the last column");

    a_edge_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && edge_value != EDGE_OFF) |->
            (({1'b0, out_col} + SIZE_W'(1)) < width_lim))
        else $error("edge marked on last column");

endmodule

### hw/rtl/gtem_front.sv
// Front end: takes pixel words, tracks row and column, holds the line buffer
// and computes the edge decision. Depends on gtem_pkg.
module gtem_front
    import gtem_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [PIX_W-1:0]  pixel,
    input  logic [PIX_W-1:0]  threshold,
    input  logic [SIZE_W-1:0] width_lim,
    input  logic [SIZE_W-1:0] height_lim,
    input  logic              q_full,
    output logic              q_push,
    output item_t             q_item
);

    logic [PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [PIX_W-1:0] rd_reg;

    logic [COL_W-1:0] col_count_reg, col_count_next;
    logic [ROW_W-1:0] row_count_reg, row_count_next;

    logic             sb_valid_reg, sb_valid_next;
    logic [PIX_W-1:0] sb_px_reg;
    logic [PIX_W-1:0] sb_above_reg;
    logic [ROW_W-1:0] sb_row_reg;
    logic [COL_W-1:0] sb_col_reg;
    logic             sb_last_col_reg;
    logic             sb_last_row_reg;

    logic             accept;
    logic             last_col;
    logic             last_row;
    logic [COL_W-1:0] rd_addr;
    logic [PIX_W-1:0] d_below;
    logic [PIX_W-1:0] d_right;

    assign in_ready = !sb_valid_reg || !q_full;
    assign accept   = in_valid && in_ready;
    assign q_push   = sb_valid_reg && !q_full;

    assign last_col = ({1'b0, col_count_reg} + SIZE_W'(1)) >= width_lim;
    assign last_row = ({1'b0, row_count_reg} + SIZE_W'(1)) >= height_lim;
    // prefetch the next right neighbor, or column zero for the coming row
    assign rd_addr  = last_col ? '0 : col_count_reg + COL_W'(1);

    always_comb
    begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        sb_valid_next  = q_push ? 1'b0 : sb_valid_reg;
        if (accept)
        begin
            sb_valid_next = 1'b1;
            if (last_col)
            begin
                col_count_next = '0;
                row_count_next = last_row ? '0 : row_count_reg + ROW_W'(1);
            end
            else
            begin
                col_count_next = col_count_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            sb_valid_reg  <= 1'b0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            sb_valid_reg  <= sb_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            line_mem[col_count_reg] <= pixel;
            rd_reg <= (rd_addr == col_count_reg) ? pixel : line_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sb_px_reg       <= pixel;
            sb_above_reg    <= rd_reg;
            sb_row_reg      <= row_count_reg;
            sb_col_reg      <= col_count_reg;
            sb_last_col_reg <= last_col;
            sb_last_row_reg <= last_row;
        end
    end

    assign d_below = abs_diff(sb_px_reg, sb_above_reg);
    assign d_right = abs_diff(rd_reg, sb_above_reg);

    always_comb
    begin
        q_item.edge_hit = !sb_last_col_reg && ((d_below > threshold) || (d_right > threshold));
        q_item.has_edge = (sb_row_reg != '0);
        q_item.has_zero = sb_last_row_reg;
        q_item.last_col = sb_last_col_reg;
        q_item.row      = sb_row_reg;
        q_item.col      = sb_col_reg;
    end

endmodule

### hw/rtl/gtem_fifo.sv
// Short queue of classified items between front and back end.
// Depends on gtem_pkg.
module gtem_fifo
    import gtem_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output item_t head,
    output logic  full,
    output logic  empty
);

    item_t            slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full  = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### hw/rtl/gtem_back.sv
// Back end: expands each queued item into its result words and drives the
// output register. Depends on gtem_pkg.
module gtem_back
    import gtem_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  item_t            head,
    input  logic             q_empty,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [PIX_W-1:0] edge_value,
    output logic [ROW_W-1:0] out_row,
    output logic [COL_W-1:0] out_col,
    output logic             frame_end
);

    logic             out_valid_reg, out_valid_next;
    logic             first_done_reg, first_done_next;
    logic [PIX_W-1:0] value_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    logic             end_reg;

    logic load;
    logic emit;
    logic sel_first;

    assign load = !out_valid_reg || out_ready;

    always_comb
    begin
        q_pop     = 1'b0;
        emit      = 1'b0;
        sel_first = 1'b0;
        if (!q_empty)
        begin
            if (!head.has_edge && !head.has_zero)
            begin
                q_pop = 1'b1;
            end
            else if (load)
            begin
                emit = 1'b1;
                if (head.has_edge && !first_done_reg)
                begin
                    sel_first = 1'b1;
                    q_pop     = !head.has_zero;
                end
                else
                begin
                    q_pop = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        first_done_next = first_done_reg;
        if (q_pop)
        begin
            first_done_next = 1'b0;
        end
        else if (emit && sel_first)
        begin
            first_done_next = 1'b1;
        end
        out_valid_next = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            first_done_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            first_done_reg <= first_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            col_reg <= head.col;
            if (sel_first)
            begin
                value_reg <= head.edge_hit ? EDGE_ON : EDGE_OFF;
                row_reg   <= head.row - ROW_W'(1);
                end_reg   <= 1'b0;
            end
            else
            begin
                value_reg <= EDGE_OFF;
                row_reg   <= head.row;
                end_reg   <= head.last_col;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign edge_value = value_reg;
    assign out_row    = row_reg;
    assign out_col    = col_reg;
    assign frame_end  = end_reg;

endmodule

### sim/tb_gradient_threshold_edge_map.sv
// Self-checking bench for gradient_threshold_edge_map: directed table, clamped sizes, random frames.
// Expected words: typed table rows, else the cycle-free predictor. Depends on gtem_pkg and the RTL.
`timescale 1ns / 100ps

module tb_gradient_threshold_edge_map;
    import gtem_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } edge_word_t;

    typedef enum logic {STEP_PIXEL, STEP_WRITE} step_kind_e;

    typedef struct packed {
        step_kind_e           kind;
        logic [CFG_IDX_W-1:0] addr;
        logic [CFG_W-1:0]     data;
        logic                 typed;
        logic [1:0]           n_typed;
        edge_word_t           w0;
        edge_word_t           w1;
    } dir_step_t;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam edge_word_t NO_WORD       = '0;
    localparam int         N_DIRECTED    = 31;
    localparam int         RAND_PIXELS   = 1750;
    localparam int         SETTLE_CYCLES = 8;

    localparam dir_step_t DIRECTED [N_DIRECTED] = '{
        '{STEP_WRITE, REG_WIDTH,     12'd0,   1'b0, 2'd0, NO_WORD, NO_WORD},
        '{STEP_WRITE, REG_HEIGHT,    12'd0,   1'b0, 2'd0, NO_WORD, NO_WORD},
        '{STEP_WRITE, REG_THRESHOLD, 12'd0,   1'b0, 2'd0, NO_WORD, NO_WORD},
        '{STEP_PIXEL, REG_SPARE,     12'hAA,  1'b1, 2'd1,
          '{EDGE_OFF, 11'd0, 11'd0, 1'b1}, NO_WORD},
        '{STEP_WRITE, REG_WIDTH,     12'd3,   1'b0, 2'd0, NO_WORD, NO_WORD},
        '{STEP_WRITE, REG_HEIGHT,    12'd2,   1'b0, 2'd0, NO_WORD, NO_WORD},
        '{STEP_WRITE, REG_THRESHOLD, 12'd255, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{STEP_PIXEL, REG_SPARE,     12'd0,   1'b1, 2'd0, NO_WORD, NO_WORD},
        '{STEP_PIXEL, REG_SPARE,     12'd255, 1'b1, 2'd0, NO_WORD, NO_WORD},
        '{STEP_PIXEL, REG_SPARE,     12'd0,   1'b1, 2'd0, NO_WORD, NO_WORD},
        '{STEP_PIXEL, REG_SPARE,     12'd255, 1'b1, 2'd2,
          '{EDGE_OFF, 11'd0, 11'd0, 1'b0}, '{EDGE_OFF, 11'd1, 11'd0, 1'b0}},
        '{STEP_PIXEL, REG_SPARE,     12'd0,   1'b1, 2'd2,
          '{EDGE_OFF, 11'd0, 11'd1, 1'b0}, '{EDGE_OFF, 11'd1, 11'd1, 1'b0}},
        '{STEP_PIXEL, REG_SPARE,     12'd255, 1'b1, 2'd2,
          '{EDGE_OFF, 11'd0, 11'd2, 1'b0}, '{EDGE_OFF, 11'd1, 11'd2, 1'b1}},
        '{STEP_WRITE, REG_THRESHOLD, 12'd254, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{STEP_WRITE, REG_WIDTH,     12'd2,   1'b0, 2'd0, NO_WORD, NO_WORD},
        '{STEP_PIXEL, REG_SPARE,     12'd0,   1'b1, 2'd0, NO_WORD, NO_WORD},
        '{STEP_PIXEL, REG_SPARE,     12'd255, 1'b1, 2'd0, NO_WORD, NO_WORD},
        '{STEP_PIXEL, REG_SPARE,     12'd255, 1'b1, 2'd2,
          '{EDGE_ON, 11'd0, 11'd0, 1'b0}, '{EDGE_OFF, 11'd1, 11'd0, 1'b0}},
        '{STEP_PIXEL, REG_SPARE,     12'd0,   1'b1, 2'd2,
          '{EDGE_OFF, 11'd0, 11'd1, 1'b0}, '{EDGE_OFF, 11'd1, 11'd1, 1'b1}},
        '{STEP_WRITE, REG_THRESHOLD, 12'd0,   1'b0, 2'd0, NO_WORD, NO_WORD},
        '{STEP_WRITE, REG_WIDTH,     12'd3,   1'b0, 2'd0, NO_WORD, NO_WORD},
        '{STEP_WRITE, REG_HEIGHT,    12'd3,   1'b0, 2'd0, NO_WORD, NO_WORD},
        '{STEP_PIXEL, REG_SPARE,     12'd10,  1'b0, 2'd0, NO_WORD, NO_WORD},
        '{STEP_PIXEL, REG_SPARE,     12'd10,  1'b0, 2'd0, NO_WORD, NO_WORD},
        '{STEP_PIXEL, REG_SPARE,     12'd10,  1'b0, 2'd0, NO_WORD, NO_WORD},
        '{STEP_PIXEL, REG_SPARE,     12'd10,  1'b0, 2'd0, NO_WORD, NO_WORD},
        '{STEP_PIXEL, REG_SPARE,     12'd11,  1'b0, 2'd0, NO_WORD, NO_WORD},
        '{STEP_PIXEL, REG_SPARE,     12'd10,  1'b0, 2'd0, NO_WORD, NO_WORD},
        '{STEP_PIXEL, REG_SPARE,     12'd0,   1'b0, 2'd0, NO_WORD, NO_WORD},
        '{STEP_PIXEL, REG_SPARE,     12'd255, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{STEP_PIXEL, REG_SPARE,     12'd128, 1'b0, 2'd0, NO_WORD, NO_WORD}
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = REG_THRESHOLD;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [PIX_W-1:0]     pixel = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [PIX_W-1:0]     edge_value;
    logic [ROW_W-1:0]     out_row;
    logic [COL_W-1:0]     out_col;
    logic                 frame_end;

    // predictor state and configuration
    logic [PIX_W-1:0] prev_row [MAX_WIDTH];
    int unsigned      pred_row = 0;
    int unsigned      pred_col = 0;
    logic [PIX_W-1:0] thr_reg = '0;
    logic [CFG_W-1:0] width_reg = RST_WIDTH;
    logic [CFG_W-1:0] height_reg = RST_HEIGHT;

    edge_word_t  edge_words_due [$];
    edge_word_t  due_word;
    int unsigned send_gap_pct = 9;
    int unsigned recv_stall_pct = 53;
    bit          stream_open = 1'b0;
    logic [PIX_W-1:0] tone_base = '0;
    int unsigned pixels_sent = 0;
    int unsigned words_checked = 0;
    int unsigned edges_seen = 0;
    int unsigned frames_done = 0;
    int unsigned fail_count = 0;

    gradient_threshold_edge_map uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pixel      (pixel),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .edge_value (edge_value),
        .out_row    (out_row),
        .out_col    (out_col),
        .frame_end  (frame_end)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1500000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int unsigned clamp_size(input logic [CFG_W-1:0] v, input int unsigned top);
        if (v == 0)
            return 1;
        if (v > top)
            return top;
        return v;
    endfunction

    function automatic bit exceeds(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b);
        int unsigned d;
        d = (a > b) ? a - b : b - a;
        return d > thr_reg;
    endfunction

    function automatic int predict_edge_map(input logic [PIX_W-1:0] px,
                                            output edge_word_t w0, output edge_word_t w1);
        int unsigned w, h, r, c;
        int          n;
        bit          last_col, last_row, hit;
        edge_word_t  zero_word;
        w        = clamp_size(width_reg, MAX_WIDTH);
        h        = clamp_size(height_reg, MAX_HEIGHT);
        r        = pred_row;
        c        = pred_col;
        last_col = (c + 1 >= w);
        last_row = (r + 1 >= h);
        n        = 0;
        w0       = NO_WORD;
        w1       = NO_WORD;
        if (r > 0)
        begin
            hit = 1'b0;
            if (!last_col && c + 1 < MAX_WIDTH)
                hit = exceeds(px, prev_row[c]) || exceeds(prev_row[c + 1], prev_row[c]);
            w0 = '{hit ? EDGE_ON : EDGE_OFF, ROW_W'(r - 1), COL_W'(c), 1'b0};
            n  = 1;
        end
        prev_row[c] = px;
        if (last_row)
        begin
            zero_word = '{EDGE_OFF, ROW_W'(r), COL_W'(c), last_col};
            if (n == 0)
                w0 = zero_word;
            else
                w1 = zero_word;
            n++;
        end
        if (last_col)
        begin
            pred_col = 0;
            pred_row = last_row ? 0 : r + 1;
        end
        else
            pred_col = c + 1;
        return n;
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return 8'd0;
        if (pick == 1)
            return 8'd255;
        if (pick < 5)
            return PIX_W'($urandom_range(0, 255));
        return PIX_W'(tone_base + $urandom_range(0, 15));
    endfunction

    // drop valid, wait for all words, then hold off while a first-row pixel may be in flight
    task automatic settle();
        if (stream_open)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            while (edge_words_due.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
            stream_open = 1'b0;
        end
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] addr, input logic [CFG_W-1:0] data);
        settle();
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (addr)
            REG_THRESHOLD: thr_reg = data[PIX_W-1:0];
            REG_WIDTH:     width_reg = data;
            REG_HEIGHT:    height_reg = data;
            default:       ;
        endcase
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] px, input int step);
        int         n;
        edge_word_t w0, w1;
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        pixel    <= px;
        do @(posedge clk); while (!in_ready);
        stream_open = 1'b1;
        pixels_sent++;
        n = predict_edge_map(px, w0, w1);
        if (step >= 0 && DIRECTED[step].typed)
        begin
            n  = int'(DIRECTED[step].n_typed);
            w0 = DIRECTED[step].w0;
            w1 = DIRECTED[step].w1;
        end
        if (n > 0)
            edge_words_due.push_back(w0);
        if (n > 1)
            edge_words_due.push_back(w1);
    endtask

    task automatic check_field(input string what, input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            fail_count++;
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (edge_words_due.size() == 0)
            begin
                fail_count++;
                $display("%0t: expected no word, got value %0d row %0d col %0d end %0d",
                         $time, edge_value, out_row, out_col, frame_end);
            end
            else
            begin
                due_word = edge_words_due.pop_front();
                check_field("edge_value", due_word.value, edge_value);
                check_field("out_row", due_word.row, out_row);
                check_field("out_col", due_word.col, out_col);
                check_field("frame_end", due_word.last, frame_end);
                words_checked++;
                if (edge_value == EDGE_ON)
                    edges_seen++;
                if (frame_end)
                    frames_done++;
            end
        end
    end

    initial
    begin
        int unsigned rand_start, done, img_px, cut, pick;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (DIRECTED[i].kind == STEP_WRITE)
                cfg_write(DIRECTED[i].addr, DIRECTED[i].data);
            else
                send_pixel(DIRECTED[i].data[PIX_W-1:0], i);
        end

        rand_start = pixels_sent;
        done = 0;
        while (done < RAND_PIXELS)
        begin
            if (done < RAND_PIXELS / 3)
            begin
                send_gap_pct   = 9;
                recv_stall_pct = 53;
            end
            else if (done < 2 * RAND_PIXELS / 3)
            begin
                send_gap_pct   = 53;
                recv_stall_pct = 9;
            end
            else
            begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            pick = $urandom_range(7);
            cfg_write(REG_THRESHOLD, CFG_W'((pick == 0) ? 0 : (pick == 1) ? 255 :
                      (pick < 5) ? $urandom_range(0, 24) : $urandom_range(0, 255)));
            pick = $urandom_range(15);
            cfg_write(REG_WIDTH, CFG_W'((pick == 0) ? 0 : (pick == 1) ? $urandom_range(25, 80) :
                      $urandom_range(1, 24)));
            cfg_write(REG_HEIGHT, CFG_W'(($urandom_range(7) == 0) ? 0 : $urandom_range(1, 10)));
            if ($urandom_range(5) == 0)
                cfg_write(REG_SPARE, CFG_W'($urandom_range(0, 4095)));
            tone_base = PIX_W'($urandom);
            img_px = clamp_size(width_reg, MAX_WIDTH) * clamp_size(height_reg, MAX_HEIGHT);
            if ($urandom_range(3) == 0 && img_px > 1)
            begin
                // stop mid-frame, retune, shrink the row or move the last row, then finish
                cut = $urandom_range(1, img_px - 1);
                repeat (cut) send_pixel(rand_pixel(), -1);
                cfg_write(REG_THRESHOLD, CFG_W'($urandom_range(0, 255)));
                if ($urandom_range(1))
                    cfg_write(REG_WIDTH,
                              CFG_W'($urandom_range(0, clamp_size(width_reg, MAX_WIDTH))));
                if ($urandom_range(1))
                    cfg_write(REG_HEIGHT, CFG_W'($urandom_range(0, 12)));
                while (pred_row != 0 || pred_col != 0)
                    send_pixel(rand_pixel(), -1);
            end
            else
                repeat (img_px) send_pixel(rand_pixel(), -1);
            done = pixels_sent - rand_start;
        end

        settle();
        $display("Streamed %0d pixels in %0d frames, clamped sizes and mid-frame changes included.",
                 pixels_sent, frames_done);
        $display("Compared %0d result words, %0d of them marked as edges.",
                 words_checked, edges_seen);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/gtem_pkg.sv
hw/rtl/gtem_front.sv
hw/rtl/gtem_fifo.sv
hw/rtl/gtem_back.sv
hw/rtl/gradient_threshold_edge_map.sv
sim/tb_gradient_threshold_edge_map.sv
